FILE: design/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Clock is clk, reset is rst; every check is disabled while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge.
`define AWDSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define AWDSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/awdsd_pkg.sv
// Types and constants for the adaptive-width delta sample decoder.
// No dependencies; imported by every decoder module.
`timescale 1ns / 1ps
package awdsd_pkg;

  localparam int COUNT_WIDTH = 25;
  localparam logic [3:0] MAX_CODE_WIDTH = 4'd9;
  localparam logic [3:0] START_WIDTH = 4'd8;

  typedef enum logic [1:0] {
    PH_LIMIT = 2'd0,
    PH_FIRST = 2'd1,
    PH_CODES = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FIRST = 2'd1,
    ST_BITS  = 2'd2
  } seq_state_t;

  // Decoder state entering one bit step.
  typedef struct packed {
    logic       bit_in;
    logic [3:0] code_width;
    logic [8:0] partial_code;
    logic [3:0] partial_bits;
    logic [7:0] run_count;
    logic [7:0] run_limit;
    logic [7:0] accumulator;
  } step_in_t;

  // Decoder state leaving one bit step, plus what the step produced.
  typedef struct packed {
    logic [3:0] code_width;
    logic [8:0] partial_code;
    logic [3:0] partial_bits;
    logic [7:0] run_count;
    logic [7:0] accumulator;
    logic       emit;
    logic       early;
  } step_out_t;

  typedef struct packed {
    logic [7:0] sample_value;
    logic       sample_valid;
    logic       is_last;
    logic       ended_early;
  } result_t;

endpackage

FILE: design/adaptive_width_delta_sample_decoder_unit.sv
// Top level of the adaptive-width delta sample decoder: sequencer, decoder state
// and sample counter. Depends on awdsd_pkg, awdsd_bit_unit, awdsd_out_buf and assert_macros.svh.
//
// Usage:
//   sample_length is written over the cfg channel (cfg_ready is always high); the
//   user must write it only while idle, not enforced by the block; zero drops every byte.
//   Stream bytes enter on in_valid/in_stall; results leave on out_valid/
//   out_stall through a one-entry output register.
//   A first-sample byte gives one result. A code byte is taken in and then
//   stepped bit by bit through the shared bit-step unit, giving up to eight
//   results, each loaded into the output register at the end of its bit step.
//   in_stall is high while a byte is in work.
//   When the receiver stalls and the output register is full, the bit step
//   that produces a result holds until the register frees; no result is lost.
//   Reset (rst, synchronous) clears sample_length and all decoder state and
//   leaves the block waiting for a run-limit byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adaptive_width_delta_sample_decoder_unit import awdsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_WIDTH-1:0] sample_length,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             stream_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             sample_value,
  output logic                   sample_valid,
  output logic                   is_last,
  output logic                   ended_early
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  seq_state_t             state;
  seq_state_t             state_next;
  phase_t                 phase;
  logic [COUNT_WIDTH-1:0] sample_len;
  logic [7:0]             byte_reg;
  logic [2:0]             bit_idx;
  logic [7:0]             run_limit;
  logic [7:0]             accumulator;
  logic [3:0]             code_width;
  logic [7:0]             run_count;
  logic [8:0]             partial_code;
  logic [3:0]             partial_bits;
  logic [COUNT_WIDTH-1:0] samples_done;

  logic                   accept;
  logic                   out_free;
  logic                   step_en;
  logic                   first_en;
  logic                   load;
  logic [COUNT_WIDTH-1:0] done_inc;
  logic                   last;
  result_t                load_data;
  result_t                out_data;
  step_in_t               step_in;
  step_out_t              step_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_len <= '0;
    end else if (cfg_valid) begin
      sample_len <= sample_length;
    end
  end

  assign step_in.bit_in       = byte_reg[bit_idx];
  assign step_in.code_width   = code_width;
  assign step_in.partial_code = partial_code;
  assign step_in.partial_bits = partial_bits;
  assign step_in.run_count    = run_count;
  assign step_in.run_limit    = run_limit;
  assign step_in.accumulator  = accumulator;

  awdsd_bit_unit u_bit_unit (
    .step_in  (step_in),
    .step_out (step_out)
  );

  assign done_inc = (samples_done != COUNT_MAX) ? samples_done + COUNT_WIDTH'(1)
                                                : samples_done;
  assign last     = done_inc >= sample_len;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && sample_len != '0) begin
          if (phase == PH_CODES) begin
            state_next = ST_BITS;
          end else if (phase == PH_FIRST) begin
            state_next = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_BITS: begin
        if (step_en && (bit_idx == 3'd7 || (step_out.emit && (step_out.early || last)))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    step_en   = 1'b0;
    first_en  = 1'b0;
    load      = 1'b0;
    load_data = '0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_FIRST: begin
        first_en               = out_free;
        load                   = out_free;
        load_data.sample_value = byte_reg;
        load_data.sample_valid = 1'b1;
        load_data.is_last      = last;
      end
      ST_BITS: begin
        // Hold the step while its result has nowhere to go.
        step_en = !step_out.emit || out_free;
        load    = step_en && step_out.emit;
        if (step_out.early) begin
          load_data.sample_valid = 1'b0;
          load_data.is_last      = 1'b1;
          load_data.ended_early  = 1'b1;
        end else begin
          load_data.sample_value = step_out.accumulator;
          load_data.sample_valid = 1'b1;
          load_data.is_last      = last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_LIMIT;
      bit_idx      <= '0;
      run_limit    <= '0;
      accumulator  <= '0;
      code_width   <= START_WIDTH;
      run_count    <= '0;
      partial_code <= '0;
      partial_bits <= '0;
      samples_done <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        bit_idx <= '0;
        if (sample_len != '0 && phase != PH_FIRST && phase != PH_CODES) begin
          run_limit    <= stream_byte;
          code_width   <= START_WIDTH;
          run_count    <= '0;
          partial_code <= '0;
          partial_bits <= '0;
          samples_done <= '0;
          phase        <= PH_FIRST;
        end
      end
      if (first_en) begin
        accumulator  <= byte_reg;
        samples_done <= done_inc;
        phase        <= last ? PH_LIMIT : PH_CODES;
      end
      if (step_en) begin
        bit_idx <= bit_idx + 3'd1;
        if (step_out.emit && step_out.early) begin
          phase        <= PH_LIMIT;
          partial_code <= step_out.partial_code;
          partial_bits <= step_out.partial_bits;
        end else begin
          code_width   <= step_out.code_width;
          partial_code <= step_out.partial_code;
          partial_bits <= step_out.partial_bits;
          run_count    <= step_out.run_count;
          accumulator  <= step_out.accumulator;
          if (step_out.emit) begin
            samples_done <= done_inc;
            if (last) begin
              phase <= PH_LIMIT;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_reg <= stream_byte;
    end
  end

  awdsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_data (load_data),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign sample_value = out_data.sample_value;
  assign sample_valid = out_data.sample_valid;
  assign is_last      = out_data.is_last;
  assign ended_early  = out_data.ended_early;

  `AWDSD_ASSERT(a_width_range, code_width >= 4'd1 && code_width <= MAX_CODE_WIDTH, "code width out of range")
  `AWDSD_ASSERT(a_early_marker, !(out_valid && ended_early) || (!sample_valid && is_last), "bad early-end marker")
  `AWDSD_ASSERT(a_partial_short, partial_bits < code_width || state != ST_BITS, "partial code overran width")
  `AWDSD_ASSERT_NEXT(a_last_ends_run, load && load_data.is_last, phase == PH_LIMIT && state == ST_IDLE, "run did not end after last result")

endmodule

FILE: design/awdsd_bit_unit.sv
// One bit step of the code extractor: shifts a stream bit into the partial
// code and, when a code completes, applies it. Depends on awdsd_pkg.
`timescale 1ns / 1ps
module awdsd_bit_unit import awdsd_pkg::*; (
  input  step_in_t  step_in,
  output step_out_t step_out
);

  logic [3:0] w;
  logic [3:0] w_narrow;
  logic [8:0] pc;
  logic [3:0] pb;
  logic [3:0] pb_inc;
  logic [7:0] rc_inc;
  logic [7:0] half;

  always_comb begin
    // Clamp the width into the legal range.
    w = step_in.code_width;
    if (w == 4'd0) begin
      w = 4'd1;
    end else if (w > MAX_CODE_WIDTH) begin
      w = MAX_CODE_WIDTH;
    end
    w_narrow = (w > 4'd1) ? w - 4'd1 : w;

    pc = step_in.partial_code;
    pb = step_in.partial_bits;
    if (pb >= MAX_CODE_WIDTH) begin
      pc = '0;
      pb = '0;
    end
    pc[pb] = step_in.bit_in;
    pb_inc = pb + 4'd1;
    half = pc[8:1];
    rc_inc = step_in.run_count + 8'd1;

    step_out.code_width   = step_in.code_width;
    step_out.partial_code = pc;
    step_out.partial_bits = pb_inc;
    step_out.run_count    = step_in.run_count;
    step_out.accumulator  = step_in.accumulator;
    step_out.emit         = 1'b0;
    step_out.early        = 1'b0;

    if (pb_inc >= w) begin
      step_out.partial_code = '0;
      step_out.partial_bits = '0;
      if (pc == 9'd0) begin
        if (w >= MAX_CODE_WIDTH) begin
          step_out.emit  = 1'b1;
          step_out.early = 1'b1;
        end else begin
          step_out.code_width = w + 4'd1;
          step_out.run_count  = '0;
        end
      end else begin
        step_out.accumulator = pc[0] ? step_in.accumulator - half
                                     : step_in.accumulator + half;
        step_out.code_width = w;
        if (pc[w - 4'd1]) begin
          step_out.run_count = '0;
        end else if (rc_inc >= step_in.run_limit) begin
          step_out.code_width = w_narrow;
          step_out.run_count  = '0;
        end else begin
          step_out.run_count = rc_inc;
        end
        step_out.emit = 1'b1;
      end
    end
  end

endmodule

FILE: design/awdsd_out_buf.sv
// Output register for decoded results, parting the decoder from the receiver.
// Depends on awdsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module awdsd_out_buf import awdsd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    full;
  result_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (!out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  assign free      = !full || !out_stall;
  assign out_valid = full;
  assign out_data  = data;

  `AWDSD_ASSERT(a_load_when_free, !load || !full || !out_stall, "result overwritten while stalled")

endmodule

FILE: bench/sample_stream_checker.sv
// Checker for the adaptive-width delta sample decoder: watches the config, byte and
// sample channels, predicts every result and compares it in order.
// Depends on awdsd_pkg.
`timescale 1ns / 1ps
module sample_stream_checker import awdsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [COUNT_WIDTH-1:0] sample_length,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             stream_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [7:0]             sample_value,
  input  logic                   sample_valid,
  input  logic                   is_last,
  input  logic                   ended_early,
  output int                     fail_count,
  output int                     pending,
  output logic                   run_active
);

  localparam int REPORT_LIMIT = 10;

  phase_t                 phase;
  logic [7:0]             limit_byte;
  logic [7:0]             acc;
  logic [3:0]             width;
  logic [7:0]             run_cnt;
  logic [8:0]             code_bits;
  logic [3:0]             code_len;
  logic [COUNT_WIDTH-1:0] done_count;
  logic [COUNT_WIDTH-1:0] length_reg;

  result_t expected_samples[$];

  initial begin
    fail_count = 0;
    pending = 0;
    run_active = 1'b0;
  end

  function logic bump_done();
    if (done_count != '1) done_count = done_count + COUNT_WIDTH'(1);
    return done_count >= length_reg;
  endfunction

  task push_sample(input logic [7:0] value, input logic valid, input logic last,
                   input logic early);
    result_t r;
    r.sample_value = value;
    r.sample_valid = valid;
    r.is_last = last;
    r.ended_early = early;
    expected_samples.push_back(r);
  endtask

  task decode_byte(input logic [7:0] b);
    logic [3:0] w;
    logic [8:0] v;
    logic       last;
    int         i;
    if (length_reg == '0) return;
    case (phase)
      PH_FIRST: begin
        acc = b;
        last = bump_done();
        push_sample(acc, 1'b1, last, 1'b0);
        phase = last ? PH_LIMIT : PH_CODES;
      end
      PH_CODES: begin
        for (i = 0; i < 8; i++) begin
          w = width;
          if (w < 4'd1) w = 4'd1;
          else if (w > MAX_CODE_WIDTH) w = MAX_CODE_WIDTH;
          if (code_len >= MAX_CODE_WIDTH) begin
            code_len = '0;
            code_bits = '0;
          end
          // later bits land above earlier ones, across byte boundaries
          code_bits = code_bits | ({8'd0, b[i]} << code_len);
          code_len = code_len + 4'd1;
          if (code_len >= w) begin
            v = code_bits;
            code_bits = '0;
            code_len = '0;
            if (v == 9'd0) begin
              if (w >= MAX_CODE_WIDTH) begin
                push_sample(8'd0, 1'b0, 1'b1, 1'b1);
                phase = PH_LIMIT;
                return;
              end
              width = w + 4'd1;
              run_cnt = '0;
            end else begin
              acc = v[0] ? acc - v[8:1] : acc + v[8:1];
              if ((v >> (w - 4'd1)) != 9'd0) begin
                run_cnt = '0;
              end else begin
                run_cnt = run_cnt + 8'd1;
                // narrow once enough codes in a row leave the top bit clear
                if (run_cnt >= limit_byte) begin
                  if (w > 4'd1) w = w - 4'd1;
                  run_cnt = '0;
                end
              end
              width = w;
              last = bump_done();
              push_sample(acc, 1'b1, last, 1'b0);
              if (last) begin
                phase = PH_LIMIT;
                return;
              end
            end
          end
        end
      end
      default: begin
        limit_byte = b;
        width = START_WIDTH;
        run_cnt = '0;
        code_bits = '0;
        code_len = '0;
        done_count = '0;
        phase = PH_FIRST;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      phase = PH_LIMIT;
      limit_byte = '0;
      acc = '0;
      width = START_WIDTH;
      run_cnt = '0;
      code_bits = '0;
      code_len = '0;
      done_count = '0;
      length_reg = '0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.sample_value = sample_value;
        got.sample_valid = sample_valid;
        got.is_last = is_last;
        got.ended_early = ended_early;
        if (expected_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected sample: value %h valid %b last %b early %b",
                     $realtime, got.sample_value, got.sample_valid, got.is_last,
                     got.ended_early);
        end else begin
          want = expected_samples.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: sample mismatch: exp value %h valid %b last %b early %b, got value %h valid %b last %b early %b",
                       $realtime, want.sample_value, want.sample_valid, want.is_last,
                       want.ended_early, got.sample_value, got.sample_valid,
                       got.is_last, got.ended_early);
          end
        end
      end
      if (cfg_valid && cfg_ready) length_reg = sample_length;
      if (in_valid && !in_stall) decode_byte(stream_byte);
    end
    pending = expected_samples.size();
    run_active = (phase == PH_CODES);
  end

endmodule

FILE: bench/tb_adaptive_width_delta_sample_decoder_unit.sv
// Testbench top for the adaptive-width delta sample decoder: clock, reset, byte and
// config stimulus, receiver stalls and the verdict.
// Depends on awdsd_pkg, the decoder RTL and sample_stream_checker.
`timescale 1ns / 1ps
module tb_adaptive_width_delta_sample_decoder_unit;
  import awdsd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] MAX_LENGTH = 25'd33554430;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 160;
  localparam int TARGET_ITEMS = 250;
  localparam int ROUND_ITEMS = 40;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COUNT_WIDTH-1:0] sample_length = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             stream_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             sample_value;
  logic                   sample_valid;
  logic                   is_last;
  logic                   ended_early;

  int   fail_count;
  int   pending;
  logic run_active;

  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  int   hold_req = 0;
  int   bytes_sent = 0;

  always #1 clk = ~clk;

  adaptive_width_delta_sample_decoder_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sample_length(sample_length),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_value (sample_value),
    .sample_valid (sample_valid),
    .is_last      (is_last),
    .ended_early  (ended_early)
  );

  sample_stream_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sample_length(sample_length),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_value (sample_value),
    .sample_valid (sample_valid),
    .is_last      (is_last),
    .ended_early  (ended_early),
    .fail_count   (fail_count),
    .pending      (pending),
    .run_active   (run_active)
  );

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin : rx_side
    int hold;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !rx_quiet && ($urandom_range(99) < 7);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Call at a falling edge; returns just after the rising edge that takes the byte.
  task automatic offer_byte(input logic [7:0] b);
    while (!tx_quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    bytes_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    offer_byte(b);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [COUNT_WIDTH-1:0] len);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    sample_length <= len;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_code_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1, 2:    return 8'($urandom & $urandom & $urandom);
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Run: limit byte, first sample, codes to the close or cap; or 1-3 random bytes.
  task automatic make_run();
    int n;
    int k;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      return;
    end
    case ($urandom_range(3))
      0:       send_byte(8'h00);
      1:       send_byte(8'h01);
      2:       send_byte(8'($urandom_range(2, 6)));
      default: send_byte(8'($urandom));
    endcase
    send_byte(8'($urandom));
    n = $urandom_range(4, 48);
    for (k = 0; k < n; k++) begin
      @(negedge clk);
      if (!run_active) begin
        in_valid <= 1'b0;
        break;
      end
      offer_byte(random_code_byte());
    end
  endtask

  initial begin : stimulus
    logic [COUNT_WIDTH-1:0] len;
    int items;
    int round;
    int start;
    int k;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // decoding disabled after reset: drop these
    send_byte(8'h00);
    send_byte(8'hFF);

    // full-width codes, extremes of the byte
    write_length(25'd3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h02);
    // limit zero narrows at once; the run closes mid-byte
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h02);
    send_byte(8'hFF);

    // zero code widens to nine, then a zero nine-bit code ends early
    write_length(25'd10);
    send_byte(8'h05);
    send_byte(8'h10);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);

    // shorten the length in the middle of a run
    write_length(MAX_LENGTH);
    send_byte(8'h03);
    send_byte(8'h7F);
    send_byte(8'hAA);
    send_byte(8'h55);
    write_length(25'd2);
    send_byte(8'h33);

    write_length('0);
    send_byte(8'h5A);

    // long receiver hold-off while bytes keep coming
    write_length(MAX_LENGTH);
    hold_req = HOLD_CYCLES;
    send_byte(8'h02);
    send_byte(8'($urandom));
    repeat (14) send_byte(random_code_byte());

    items = 0;
    round = 0;
    while (items < TARGET_ITEMS) begin
      case ($urandom_range(5))
        0:       len = 25'd1;
        1:       len = MAX_LENGTH;
        2:       len = COUNT_WIDTH'($urandom_range(2, 8));
        3:       len = COUNT_WIDTH'($urandom_range(9, 40));
        4:       len = '0;
        default: len = COUNT_WIDTH'($urandom_range(1000, MAX_LENGTH));
      endcase
      if (round == 0) len = 25'd1;
      write_length(len);
      tx_quiet = (round == 2);
      rx_quiet = (round == 2);
      if (len == '0) begin
        repeat (3) send_byte(8'($urandom));
      end else begin
        start = bytes_sent;
        while (bytes_sent - start < ROUND_ITEMS && items + bytes_sent - start < TARGET_ITEMS)
          make_run();
        items += bytes_sent - start;
      end
      round++;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    for (k = 0; k < 20000 && pending != 0; k++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
